FILE: design/mqtr_pkg.sv
// Shared types and constants for the quarter-turn matrix rotator.
// Holds the beat payload structs, register indexes and operation codes.
// No dependencies.
`timescale 1ns / 1ps

package mqtr_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Wide enough to compare a 7-bit register with a maximum of up to 256.
  localparam int DIM_CMP_W = 9;

  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TURNS = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_CW90  = 2'd1;
  localparam logic [1:0] TURN_HALF  = 2'd2;
  localparam logic [1:0] TURN_CW270 = 2'd3;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] element_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               end_of_row;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic [6:0] row_count;
    logic [6:0] col_count;
    logic [1:0] quarter_turns;
  } cfg_regs_t;

  // Per-beat command from the address generator to the store and output stage.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic end_of_row;
    logic last;
  } req_ctl_t;

endpackage

FILE: design/mqtr_store.sv
// Element store: single-port synchronous RAM with registered read data.
// Depends on mqtr_pkg for the request control struct.
`timescale 1ns / 1ps

module mqtr_store #(
  parameter int MAX_ROWS = mqtr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mqtr_pkg::MAX_COLS_DEF
) (
  input  logic                                      clk,
  input  mqtr_pkg::req_ctl_t                        ctl,
  input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]      addr,
  input  logic [31:0]                               wdata,
  output logic [31:0]                               rdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // Read data only moves on a fetch, so a stalled result keeps its value.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/mqtr_addr_gen.sv
// Load and readout sequencing: counters, rotated source address and row marks.
// Depends on mqtr_pkg for payload, configuration and control types.
`timescale 1ns / 1ps

module mqtr_addr_gen #(
  parameter int MAX_ROWS = mqtr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mqtr_pkg::MAX_COLS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  mqtr_pkg::cfg_regs_t                       cfg,
  input  logic                                      accept,
  input  mqtr_pkg::in_beat_t                        in_beat,
  output mqtr_pkg::req_ctl_t                        ctl,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]      addr,
  output logic [31:0]                               wdata
);

  localparam int AW   = $clog2(MAX_ROWS * MAX_COLS);
  localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DW   = $clog2(MAXD + 1);
  localparam int TW   = 2 * DW;
  localparam int CW   = mqtr_pkg::DIM_CMP_W;

  logic [AW-1:0] load_pos_r, load_pos_nxt;
  logic [DW-1:0] row_idx_r, row_idx_nxt;
  logic [DW-1:0] col_idx_r, col_idx_nxt;
  logic          load_done_r, load_done_nxt;

  logic [CW-1:0] row_ext, col_ext;
  logic [DW-1:0] rows, cols, out_rows, out_cols, i_idx, j_idx, src_r, src_c;
  logic [TW-1:0] total, load_cnt, src_lin;
  logic          is_load, do_write, do_read, eor, fin;

  // Dimension clamp: zero counts as one, anything above the maximum as the maximum.
  always_comb begin
    row_ext = CW'(cfg.row_count);
    col_ext = CW'(cfg.col_count);
    if (row_ext == '0) begin
      rows = DW'(1);
    end else if (row_ext > CW'(MAX_ROWS)) begin
      rows = DW'(MAX_ROWS);
    end else begin
      rows = DW'(row_ext);
    end
    if (col_ext == '0) begin
      cols = DW'(1);
    end else if (col_ext > CW'(MAX_COLS)) begin
      cols = DW'(MAX_COLS);
    end else begin
      cols = DW'(col_ext);
    end
  end

  always_comb begin
    is_load  = (in_beat.operation == mqtr_pkg::OP_LOAD);
    total    = TW'(rows) * TW'(cols);
    load_cnt = TW'(load_pos_r) + TW'(1);
    do_write = accept && is_load && !load_done_r;
    do_read  = accept && !is_load && load_done_r;

    if (cfg.quarter_turns[0]) begin
      out_rows = cols;
      out_cols = rows;
    end else begin
      out_rows = rows;
      out_cols = cols;
    end
    // Indices left beyond a shrunken output size stick to its last row or column.
    i_idx = (row_idx_r < out_rows) ? row_idx_r : out_rows - DW'(1);
    j_idx = (col_idx_r < out_cols) ? col_idx_r : out_cols - DW'(1);

    case (cfg.quarter_turns)
      mqtr_pkg::TURN_NONE: begin
        src_r = i_idx;
        src_c = j_idx;
      end
      mqtr_pkg::TURN_CW90: begin
        src_r = rows - DW'(1) - j_idx;
        src_c = i_idx;
      end
      mqtr_pkg::TURN_HALF: begin
        src_r = rows - DW'(1) - i_idx;
        src_c = cols - DW'(1) - j_idx;
      end
      default: begin
        src_r = j_idx;
        src_c = cols - DW'(1) - i_idx;
      end
    endcase
    src_lin = TW'(src_r) * TW'(cols) + TW'(src_c);

    eor = (j_idx == out_cols - DW'(1));
    fin = eor && (i_idx == out_rows - DW'(1));
  end

  always_comb begin
    load_pos_nxt  = load_pos_r;
    row_idx_nxt   = row_idx_r;
    col_idx_nxt   = col_idx_r;
    load_done_nxt = load_done_r;
    if (do_write) begin
      if (load_cnt >= total) begin
        load_done_nxt = 1'b1;
      end else begin
        load_pos_nxt = load_pos_r + AW'(1);
      end
    end
    if (do_read) begin
      if (fin) begin
        row_idx_nxt   = '0;
        col_idx_nxt   = '0;
        load_pos_nxt  = '0;
        load_done_nxt = 1'b0;
      end else if (eor) begin
        row_idx_nxt = i_idx + DW'(1);
        col_idx_nxt = '0;
      end else begin
        row_idx_nxt = i_idx;
        col_idx_nxt = j_idx + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r  <= '0;
      row_idx_r   <= '0;
      col_idx_r   <= '0;
      load_done_r <= 1'b0;
    end else begin
      load_pos_r  <= load_pos_nxt;
      row_idx_r   <= row_idx_nxt;
      col_idx_r   <= col_idx_nxt;
      load_done_r <= load_done_nxt;
    end
  end

  assign ctl.wr_en      = do_write;
  assign ctl.rd_en      = do_read;
  assign ctl.end_of_row = eor;
  assign ctl.last       = fin;
  assign addr           = is_load ? load_pos_r : AW'(src_lin);
  assign wdata          = in_beat.element_value;

endmodule

FILE: design/mqtr_out_stage.sv
// Result path: holds a fetch while its read is in flight, then an output register.
// Depends on mqtr_pkg for the control struct and the output beat type.
`timescale 1ns / 1ps

module mqtr_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mqtr_pkg::req_ctl_t   ctl,
  input  logic [31:0]          rdata,
  output logic                 can_accept,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mqtr_pkg::out_beat_t  out_data
);

  logic                pend_r, pend_nxt;
  logic                pend_eor_r, pend_last_r;
  logic                out_valid_r, out_valid_nxt;
  mqtr_pkg::out_beat_t out_data_r;
  logic                out_free, move;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    move     = pend_r && out_free;
    // A new beat may enter when nothing is pending or the pending read can move on this cycle.
    can_accept = !pend_r || out_free;

    pend_nxt = pend_r;
    if (ctl.rd_en) begin
      pend_nxt = 1'b1;
    end else if (move) begin
      pend_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      pend_eor_r  <= ctl.end_of_row;
      pend_last_r <= ctl.last;
    end
    if (move) begin
      out_data_r.out_value  <= rdata;
      out_data_r.end_of_row <= pend_eor_r;
      out_data_r.last       <= pend_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/matrix_quarter_turn_rotator_core.sv
// Quarter-turn matrix rotator, top level: configuration registers and datapath.
// Throughput: one load or fetch beat per cycle while results are taken.
// A fetch result passes the registered store read and then the output register;
// out_valid rises once it reaches the output register.
// Reset is synchronous: counters, flags and valid bits clear, the shape returns to 1x1 with no
// turn, and no beat is taken while rst_n is low; store contents stay undefined until loaded.
`timescale 1ns / 1ps

module matrix_quarter_turn_rotator_core #(
  parameter int MAX_ROWS = mqtr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mqtr_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mqtr_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mqtr_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mqtr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mqtr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

  mqtr_pkg::cfg_regs_t cfg_r, cfg_nxt;
  mqtr_pkg::req_ctl_t  ctl;
  logic [AW-1:0]       addr;
  logic [31:0]         wdata, rdata;
  logic                can_accept, accept;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mqtr_pkg::CFG_ROW_COUNT:     cfg_nxt.row_count     = cfg_wdata;
        mqtr_pkg::CFG_COL_COUNT:     cfg_nxt.col_count     = cfg_wdata;
        mqtr_pkg::CFG_QUARTER_TURNS: cfg_nxt.quarter_turns = cfg_wdata[1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count     <= 7'd1;
      cfg_r.col_count     <= 7'd1;
      cfg_r.quarter_turns <= mqtr_pkg::TURN_NONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ready = can_accept && rst_n;
  assign accept   = in_valid && in_ready;

  mqtr_addr_gen #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_addr_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .in_beat (in_data),
    .ctl     (ctl),
    .addr    (addr),
    .wdata   (wdata)
  );

  mqtr_store #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_store (
    .clk   (clk),
    .ctl   (ctl),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  mqtr_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rdata      (rdata),
    .can_accept (can_accept),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the quarter-turn matrix rotator core.
// Loads random matrices, fetches them back under every turn count, and checks each
// result beat against an in-bench predictor. Depends on mqtr_pkg and the core.
`timescale 1ns / 1ps

module testbench;

  localparam int STORE_DEPTH = mqtr_pkg::MAX_ROWS_DEF * mqtr_pkg::MAX_COLS_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_BEATS = 450;

  // Predicts the turned readout and holds the result beats not yet seen.
  class rotator_scoreboard;
    logic [31:0] store_mem [STORE_DEPTH];
    int unsigned load_pos;
    int unsigned row_idx;
    int unsigned col_idx;
    bit full;
    logic [6:0] rows_reg;
    logic [6:0] cols_reg;
    logic [1:0] turns_reg;
    mqtr_pkg::out_beat_t expected_q[$];
    int errors;

    function new();
      load_pos = 0;
      row_idx = 0;
      col_idx = 0;
      full = 0;
      rows_reg = 7'd1;
      cols_reg = 7'd1;
      turns_reg = mqtr_pkg::TURN_NONE;
      errors = 0;
    endfunction

    function int unsigned dim_of(logic [6:0] v, int unsigned max_dim);
      if (v == 0) return 1;
      if (v > max_dim) return max_dim;
      return v;
    endfunction

    function void set_reg(logic [mqtr_pkg::CFG_IDX_W-1:0] idx, logic [6:0] val);
      case (idx)
        mqtr_pkg::CFG_ROW_COUNT:     rows_reg = val;
        mqtr_pkg::CFG_COL_COUNT:     cols_reg = val;
        mqtr_pkg::CFG_QUARTER_TURNS: turns_reg = val[1:0];
        default: ;
      endcase
    endfunction

    function bit is_fresh();
      return !full && load_pos == 0 && row_idx == 0 && col_idx == 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Returns 1 when the beat stored an element or produced a result.
    function bit note_input(mqtr_pkg::in_beat_t b);
      int unsigned rows, cols, total, o_rows, o_cols, i, j, sr, sc, addr;
      mqtr_pkg::out_beat_t e;
      rows = dim_of(rows_reg, mqtr_pkg::MAX_ROWS_DEF);
      cols = dim_of(cols_reg, mqtr_pkg::MAX_COLS_DEF);
      total = rows * cols;
      if (b.operation == mqtr_pkg::OP_LOAD) begin
        if (full) return 0;
        store_mem[load_pos] = b.element_value;
        if (load_pos + 1 >= total) full = 1;
        else load_pos++;
        return 1;
      end
      if (!full) return 0;
      if (turns_reg[0]) begin
        o_rows = cols;
        o_cols = rows;
      end else begin
        o_rows = rows;
        o_cols = cols;
      end
      // Indices left over from a larger output shape snap to its last row or column.
      i = (row_idx < o_rows) ? row_idx : o_rows - 1;
      j = (col_idx < o_cols) ? col_idx : o_cols - 1;
      case (turns_reg)
        mqtr_pkg::TURN_NONE: begin
          sr = i;
          sc = j;
        end
        mqtr_pkg::TURN_CW90: begin
          sr = rows - 1 - j;
          sc = i;
        end
        mqtr_pkg::TURN_HALF: begin
          sr = rows - 1 - i;
          sc = cols - 1 - j;
        end
        default: begin
          sr = j;
          sc = cols - 1 - i;
        end
      endcase
      addr = sr * cols + sc;
      e.out_value = store_mem[addr];
      e.end_of_row = (j == o_cols - 1);
      e.last = e.end_of_row && (i == o_rows - 1);
      expected_q.push_back(e);
      if (e.last) begin
        row_idx = 0;
        col_idx = 0;
        load_pos = 0;
        full = 0;
      end else if (e.end_of_row) begin
        row_idx = i + 1;
        col_idx = 0;
      end else begin
        row_idx = i;
        col_idx = j + 1;
      end
      return 1;
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(mqtr_pkg::out_beat_t got);
      mqtr_pkg::out_beat_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result beat, value %h", got.out_value));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_value !== want.out_value)
        report($sformatf("out_value %h, expected %h", got.out_value, want.out_value));
      if (got.end_of_row !== want.end_of_row)
        report($sformatf("end_of_row %b, expected %b", got.end_of_row, want.end_of_row));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  mqtr_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  mqtr_pkg::out_beat_t out_data;
  logic cfg_we;
  logic [mqtr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mqtr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  logic steady = 1'b0;
  int effective = 0;
  int quiet_cycles = 0;
  rotator_scoreboard sb = new();

  matrix_quarter_turn_rotator_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 19))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Presents one beat and returns at the edge where it is taken.
  task automatic put(logic op, logic [31:0] val);
    mqtr_pkg::in_beat_t b;
    b.operation = op;
    b.element_value = val;
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_input(b)) effective++;
    steady <= (effective >= 200 && effective < 350);
  endtask

  // Waits until every predicted result has come out and the pipeline is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [mqtr_pkg::CFG_IDX_W-1:0] idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic setup(logic [6:0] rows, logic [6:0] cols, logic [1:0] turns);
    settle();
    write_reg(mqtr_pkg::CFG_ROW_COUNT, rows);
    write_reg(mqtr_pkg::CFG_COL_COUNT, cols);
    write_reg(mqtr_pkg::CFG_QUARTER_TURNS, {5'd0, turns});
  endtask

  // Completes the current load and readout; with noise, stray beats and turn changes.
  task automatic finish_matrix(bit noisy);
    while (!sb.is_fresh()) begin
      if (!sb.full) begin
        put(mqtr_pkg::OP_LOAD, rand_val());
      end else begin
        if (noisy && $urandom_range(0, 99) < 8) put(mqtr_pkg::OP_LOAD, rand_val());
        if (noisy && $urandom_range(0, 99) < 3) begin
          settle();
          write_reg(mqtr_pkg::CFG_QUARTER_TURNS, 7'($urandom_range(0, 3)));
        end
        put(mqtr_pkg::OP_FETCH, rand_val());
      end
    end
  endtask

  function automatic logic [6:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return 7'($urandom_range(1, 6));
    if (sel < 90) return 7'($urandom_range(7, 20));
    if (sel < 95) return 7'd0;
    return 7'($urandom_range(65, 127));
  endfunction

  task automatic run_matrix();
    logic [6:0] rows, cols;
    int unsigned total;
    int brk;
    rows = pick_dim();
    cols = pick_dim();
    if (sb.dim_of(rows, mqtr_pkg::MAX_ROWS_DEF) * sb.dim_of(cols, mqtr_pkg::MAX_COLS_DEF) > 256)
      cols = 7'($urandom_range(1, 4));
    setup(rows, cols, 2'($urandom_range(0, 3)));
    total = sb.dim_of(rows, mqtr_pkg::MAX_ROWS_DEF) * sb.dim_of(cols, mqtr_pkg::MAX_COLS_DEF);
    brk = (total > 1 && $urandom_range(0, 99) < 6) ? int'($urandom_range(1, total - 1)) : -1;
    for (int k = 0; k < total; k++) begin
      if (k == brk) begin
        // Resize part way through the load; the rest follows the new shape.
        settle();
        write_reg($urandom_range(0, 1) ? mqtr_pkg::CFG_ROW_COUNT : mqtr_pkg::CFG_COL_COUNT,
                  7'($urandom_range(0, 8)));
        break;
      end
      if ($urandom_range(0, 99) < 8) put(mqtr_pkg::OP_FETCH, rand_val());
      put(mqtr_pkg::OP_LOAD, rand_val());
    end
    finish_matrix(1'b1);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= mqtr_pkg::CFG_ROW_COUNT;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset shape is 1x1: fetch too early, load, load past full, then read back.
    put(mqtr_pkg::OP_FETCH, 32'h1234_5678);
    put(mqtr_pkg::OP_LOAD, 32'h7FFF_FFFF);
    put(mqtr_pkg::OP_LOAD, 32'h8000_0000);
    put(mqtr_pkg::OP_FETCH, 32'h0);

    setup(7'd2, 7'd3, mqtr_pkg::TURN_CW90);
    put(mqtr_pkg::OP_LOAD, 32'h0000_0000);
    put(mqtr_pkg::OP_LOAD, 32'hFFFF_FFFF);
    put(mqtr_pkg::OP_LOAD, 32'h0000_0001);
    put(mqtr_pkg::OP_LOAD, 32'h8000_0000);
    put(mqtr_pkg::OP_LOAD, 32'h7FFF_FFFF);
    put(mqtr_pkg::OP_LOAD, 32'h5A5A_A5A5);
    finish_matrix(1'b0);

    // A zero row count is taken as one row.
    setup(7'd0, 7'd2, mqtr_pkg::TURN_CW270);
    finish_matrix(1'b0);

    // Shrink during the load, then change the turn count during readout.
    setup(7'd2, 7'd2, mqtr_pkg::TURN_HALF);
    repeat (3) put(mqtr_pkg::OP_LOAD, rand_val());
    settle();
    write_reg(mqtr_pkg::CFG_ROW_COUNT, 7'd1);
    put(mqtr_pkg::OP_LOAD, rand_val());
    put(mqtr_pkg::OP_FETCH, rand_val());
    settle();
    write_reg(mqtr_pkg::CFG_QUARTER_TURNS, {5'd0, mqtr_pkg::TURN_CW90});
    finish_matrix(1'b0);

    effective = 0;
    while (effective < RANDOM_BEATS) run_matrix();

    // A row count above the maximum is taken as the maximum, in one tall column.
    setup(7'd127, 7'd1, 2'($urandom_range(0, 3)));
    finish_matrix(1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
